// ----- hw/rtl/cartridge_header_decoder_unit_assert.svh -----
// Assertion macros for the cartridge header decoder unit.
// Expects clk and rst in scope at the point of use.
`ifndef CARTRIDGE_HEADER_DECODER_UNIT_ASSERT_SVH
`define CARTRIDGE_HEADER_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CHDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chdu assertion failed");

// Next-cycle implication, disabled during reset.
`define CHDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chdu assertion failed");

`endif

// ----- hw/rtl/chdu_pkg.sv -----
// Shared types, constants and size tables for the cartridge header decoder.
// No dependencies.
package chdu_pkg;

  typedef struct packed {
    logic [7:0]  type_code;
    logic [7:0]  rom_id;
    logic [7:0]  ram_id;
    logic [7:0]  cgb_byte;
    logic [15:0] header_length;
    logic [31:0] image_bytes;
  } hdr_t;

  typedef struct packed {
    logic        supported;
    logic [2:0]  mapper_kind;
    logic [23:0] rom_bytes;
    logic [17:0] ram_bytes;
    logic        colour_flag;
    logic        battery_flag;
    logic        clock_flag;
    logic        wide_bank_flag;
  } info_t;

  // Mapper kinds
  localparam logic [2:0] MAPPER_NONE       = 3'd0;
  localparam logic [2:0] MAPPER_MBC1       = 3'd1;
  localparam logic [2:0] MAPPER_MBC2       = 3'd2;
  localparam logic [2:0] MAPPER_MBC3       = 3'd3;
  localparam logic [2:0] MAPPER_MBC5       = 3'd4;
  localparam logic [2:0] MAPPER_MBC5_RUMBLE = 3'd5;

  // Cartridge type bytes
  localparam logic [7:0] TYPE_ROM_ONLY          = 8'h00;
  localparam logic [7:0] TYPE_MBC1              = 8'h01;
  localparam logic [7:0] TYPE_MBC1_RAM          = 8'h02;
  localparam logic [7:0] TYPE_MBC1_RAM_BATT     = 8'h03;
  localparam logic [7:0] TYPE_MBC2              = 8'h05;
  localparam logic [7:0] TYPE_MBC2_BATT         = 8'h06;
  localparam logic [7:0] TYPE_ROM_RAM           = 8'h08;
  localparam logic [7:0] TYPE_ROM_RAM_BATT      = 8'h09;
  localparam logic [7:0] TYPE_MBC3_RTC_BATT     = 8'h0F;
  localparam logic [7:0] TYPE_MBC3_RTC_RAM_BATT = 8'h10;
  localparam logic [7:0] TYPE_MBC3              = 8'h11;
  localparam logic [7:0] TYPE_MBC3_RAM          = 8'h12;
  localparam logic [7:0] TYPE_MBC3_RAM_BATT     = 8'h13;
  localparam logic [7:0] TYPE_MBC5              = 8'h19;
  localparam logic [7:0] TYPE_MBC5_RAM          = 8'h1A;
  localparam logic [7:0] TYPE_MBC5_RAM_BATT     = 8'h1B;
  localparam logic [7:0] TYPE_MBC5_RUMBLE       = 8'h1C;
  localparam logic [7:0] TYPE_MBC5_RUMBLE_RAM   = 8'h1D;
  localparam logic [7:0] TYPE_MBC5_RUMBLE_RAM_BATT = 8'h1E;

  // ROM size codes outside the power-of-two run
  localparam logic [7:0] ROM_CODE_MAX_POW2 = 8'h08;
  localparam logic [7:0] ROM_CODE_72_BANKS = 8'h52;
  localparam logic [7:0] ROM_CODE_80_BANKS = 8'h53;
  localparam logic [7:0] ROM_CODE_96_BANKS = 8'h54;
  localparam logic [7:0] RAM_CODE_MAX      = 8'h05;

  localparam logic [15:0] HEADER_MIN_LEN = 16'h0150;
  localparam int unsigned COLOUR_BIT     = 7;

  // Sizes in bytes
  localparam logic [23:0] ROM_32K  = 24'h008000;
  localparam logic [23:0] ROM_256K = 24'h040000;
  localparam logic [23:0] ROM_512K = 24'h080000;
  localparam logic [23:0] ROM_2M   = 24'h200000;
  localparam logic [23:0] ROM_4M   = 24'h400000;
  localparam logic [23:0] ROM_8M   = 24'h800000;
  localparam logic [23:0] ROM_72_BANKS = 24'(72 * 16 * 1024);
  localparam logic [23:0] ROM_80_BANKS = 24'(80 * 16 * 1024);
  localparam logic [23:0] ROM_96_BANKS = 24'(96 * 16 * 1024);

  localparam logic [17:0] RAM_NONE  = 18'h00000;
  localparam logic [17:0] RAM_2K    = 18'h00800;
  localparam logic [17:0] RAM_8K    = 18'h02000;
  localparam logic [17:0] RAM_32K   = 18'h08000;
  localparam logic [17:0] RAM_64K   = 18'h10000;
  localparam logic [17:0] RAM_128K  = 18'h20000;
  localparam logic [17:0] MBC2_RAM_CELLS = 18'd512;

  localparam logic [23:0] ROM_LIMIT_RESET = ROM_8M;

  // ROM size lookup; bit 24 flags a known code.
  function automatic logic [24:0] rom_lookup(input logic [7:0] code);
    logic [24:0] r;
    r = '0;
    if (code <= ROM_CODE_MAX_POW2) begin
      r = {1'b1, ROM_32K << code[3:0]};
    end else if (code == ROM_CODE_72_BANKS) begin
      r = {1'b1, ROM_72_BANKS};
    end else if (code == ROM_CODE_80_BANKS) begin
      r = {1'b1, ROM_80_BANKS};
    end else if (code == ROM_CODE_96_BANKS) begin
      r = {1'b1, ROM_96_BANKS};
    end
    return r;
  endfunction

  function automatic logic [17:0] ram_lookup(input logic [2:0] code);
    logic [17:0] r;
    case (code)
      3'd0:    r = RAM_NONE;
      3'd1:    r = RAM_2K;
      3'd2:    r = RAM_8K;
      3'd3:    r = RAM_32K;
      3'd4:    r = RAM_128K;
      3'd5:    r = RAM_64K;
      default: r = RAM_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/chdu_hdr_if.sv -----
// Header request channel: valid/ready plus one header record.
// Depends on chdu_pkg.
interface chdu_hdr_if
  import chdu_pkg::*;
();
  logic valid;
  logic ready;
  hdr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/chdu_info_if.sv -----
// Decoded cartridge info channel: valid/ready plus one info record.
// Depends on chdu_pkg.
interface chdu_info_if
  import chdu_pkg::*;
();
  logic  valid;
  logic  ready;
  info_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/chdu_cfg_if.sv -----
// Configuration write channel for the ROM size limit register.
// No dependencies.
interface chdu_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cartridge_header_decoder_unit.sv -----
// An accepted header request passes the input register, decode logic and result
// register. Throughput: one header per cycle; the pipeline stalls only while the
// result register is full and not taken.
// Reset (rst, synchronous, active high): both stages empty, ROM size limit back
// to 8 MiB. Config writes are always ready and take effect the next cycle.
// Depends on chdu_pkg, the chdu_*_if interfaces, chdu_decode and the assert header.
`include "cartridge_header_decoder_unit_assert.svh"

module cartridge_header_decoder_unit
  import chdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  chdu_hdr_if.sink    hdr,
  chdu_info_if.source info,
  chdu_cfg_if.sink    cfg
);

  // ROM size limit register
  logic [23:0] rom_limit;

  // Input stage
  logic  s1_valid;
  hdr_t  s1_hdr;

  // Decode result feeding the output register
  info_t dec_info;
  logic  advance;

  // Config channel never back-pressures.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_limit <= ROM_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      rom_limit <= cfg.data;
    end
  end

  // Output register can load when empty or being drained this cycle.
  assign advance   = !info.valid || info.ready;
  // Input stage takes a new request when empty or moving forward.
  assign hdr.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hdr.ready) begin
      s1_valid <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      s1_hdr <= hdr.data;
    end
  end

  chdu_decode u_decode (
    .hdr       (s1_hdr),
    .rom_limit (rom_limit),
    .info      (dec_info)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      info.valid <= 1'b0;
    end else if (advance) begin
      info.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      info.data <= dec_info;
    end
  end

  // A rejected header reports nothing else.
  `CHDU_ASSERT_NOW(a_reject_zero, info.valid && !info.data.supported, info.data == '0)
  // Wide banking and the clock only exist on MBC3.
  `CHDU_ASSERT_NOW(a_mbc3_only, info.valid && (info.data.wide_bank_flag || info.data.clock_flag), info.data.mapper_kind == MAPPER_MBC3)
  // MBC2 always reports its internal cell count.
  `CHDU_ASSERT_NOW(a_mbc2_ram, info.valid && info.data.supported && info.data.mapper_kind == MAPPER_MBC2, info.data.ram_bytes == MBC2_RAM_CELLS)
  // An accepted request lands in the input stage.
  `CHDU_ASSERT_NEXT(a_accept_fill, hdr.valid && hdr.ready, s1_valid)
  // A moving input stage always produces a result.
  `CHDU_ASSERT_NEXT(a_stage_move, s1_valid && advance, info.valid)

endmodule

// ----- hw/rtl/chdu_decode.sv -----
// Combinational header decode: sizes, mapper, flags and layout check.
// Depends on chdu_pkg.
module chdu_decode
  import chdu_pkg::*;
(
  input  hdr_t        hdr,
  input  logic [23:0] rom_limit,
  output info_t       info
);

  logic [24:0] rom_lut;
  logic [23:0] rom;
  logic [17:0] ram;
  logic        rom_known;
  logic        hdr_ok;
  logic        size_ok;
  logic        type_ok;
  logic        layout_ok;
  logic        ok;
  logic [2:0]  mapper;
  logic        battery;
  logic        clock_f;
  logic        wide;

  assign rom_lut   = rom_lookup(hdr.rom_id);
  assign rom_known = rom_lut[24];
  assign rom       = rom_lut[23:0];
  assign hdr_ok    = (hdr.header_length >= HEADER_MIN_LEN) && (hdr.ram_id <= RAM_CODE_MAX);
  assign size_ok   = (hdr.image_bytes == {8'd0, rom}) && (rom <= rom_limit);

  always_comb begin
    mapper    = MAPPER_NONE;
    ram       = ram_lookup(hdr.ram_id[2:0]);
    type_ok   = 1'b1;
    layout_ok = 1'b0;
    clock_f   = 1'b0;
    wide      = 1'b0;
    unique case (hdr.type_code) inside
      TYPE_ROM_ONLY: begin
        layout_ok = (rom == ROM_32K) && (ram == RAM_NONE);
      end
      TYPE_ROM_RAM, TYPE_ROM_RAM_BATT: begin
        layout_ok = (rom == ROM_32K) && (ram != RAM_NONE) && (ram <= RAM_8K);
      end
      TYPE_MBC1, TYPE_MBC1_RAM, TYPE_MBC1_RAM_BATT: begin
        mapper = MAPPER_MBC1;
        if ((rom > ROM_2M) || (ram > RAM_32K) || ((rom > ROM_512K) && (ram > RAM_8K))) begin
          layout_ok = 1'b0;
        end else if (hdr.type_code == TYPE_MBC1) begin
          layout_ok = (ram == RAM_NONE);
        end else begin
          layout_ok = (ram != RAM_NONE);
        end
      end
      TYPE_MBC2, TYPE_MBC2_BATT: begin
        // internal 512-cell RAM; the header must declare none
        mapper    = MAPPER_MBC2;
        ram       = MBC2_RAM_CELLS;
        layout_ok = (rom <= ROM_256K) && (hdr.ram_id == 8'd0);
      end
      TYPE_MBC3_RTC_BATT, TYPE_MBC3: begin
        mapper    = MAPPER_MBC3;
        clock_f   = (hdr.type_code == TYPE_MBC3_RTC_BATT);
        layout_ok = (ram == RAM_NONE) && (rom <= ROM_4M);
        wide      = layout_ok && (rom > ROM_2M);
      end
      TYPE_MBC3_RTC_RAM_BATT, TYPE_MBC3_RAM, TYPE_MBC3_RAM_BATT: begin
        mapper    = MAPPER_MBC3;
        clock_f   = (hdr.type_code == TYPE_MBC3_RTC_RAM_BATT);
        layout_ok = (ram != RAM_NONE) && (rom <= ROM_4M) && (ram <= RAM_64K);
        wide      = layout_ok && ((rom > ROM_2M) || (ram > RAM_32K));
      end
      TYPE_MBC5, TYPE_MBC5_RUMBLE: begin
        mapper    = (hdr.type_code == TYPE_MBC5) ? MAPPER_MBC5 : MAPPER_MBC5_RUMBLE;
        layout_ok = (rom <= ROM_8M) && (ram == RAM_NONE);
      end
      TYPE_MBC5_RAM, TYPE_MBC5_RAM_BATT: begin
        mapper    = MAPPER_MBC5;
        layout_ok = (rom <= ROM_8M) && (ram != RAM_NONE) && (ram <= RAM_128K);
      end
      TYPE_MBC5_RUMBLE_RAM, TYPE_MBC5_RUMBLE_RAM_BATT: begin
        mapper    = MAPPER_MBC5_RUMBLE;
        layout_ok = (rom <= ROM_8M) && (ram != RAM_NONE) && (ram <= RAM_64K);
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (hdr.type_code)
      TYPE_MBC1_RAM_BATT, TYPE_MBC2_BATT, TYPE_ROM_RAM_BATT, TYPE_MBC3_RTC_BATT,
      TYPE_MBC3_RTC_RAM_BATT, TYPE_MBC3_RAM_BATT, TYPE_MBC5_RAM_BATT,
      TYPE_MBC5_RUMBLE_RAM_BATT: battery = 1'b1;
      default:                   battery = 1'b0;
    endcase
  end

  assign ok = hdr_ok && rom_known && size_ok && type_ok && layout_ok;

  always_comb begin
    info = '0;
    if (ok) begin
      info.supported      = 1'b1;
      info.mapper_kind    = mapper;
      info.rom_bytes      = rom;
      info.ram_bytes      = ram;
      info.colour_flag    = hdr.cgb_byte[COLOUR_BIT];
      info.battery_flag   = battery;
      info.clock_flag     = clock_f;
      info.wide_bank_flag = wide;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cartridge_header_decoder_unit: header requests in, decoded info out.
// Uses chdu_pkg and the chdu_hdr_if, chdu_info_if and chdu_cfg_if interfaces.
module testbench;
  import chdu_pkg::*;

  localparam int unsigned KIB              = 1024;
  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned DRAIN_CYCLES     = 4;     // covers draining the input and result stages
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned HOLD_AFTER       = 100;   // headers taken before the long hold
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned MAX_PRINTED      = 100;

  // Every type byte that maps to a mapper; random headers draw mostly from here.
  localparam logic [7:0] KNOWN_TYPES [19] = '{
    TYPE_ROM_ONLY, TYPE_MBC1, TYPE_MBC1_RAM, TYPE_MBC1_RAM_BATT, TYPE_MBC2,
    TYPE_MBC2_BATT, TYPE_ROM_RAM, TYPE_ROM_RAM_BATT, TYPE_MBC3_RTC_BATT,
    TYPE_MBC3_RTC_RAM_BATT, TYPE_MBC3, TYPE_MBC3_RAM, TYPE_MBC3_RAM_BATT, TYPE_MBC5,
    TYPE_MBC5_RAM, TYPE_MBC5_RAM_BATT, TYPE_MBC5_RUMBLE, TYPE_MBC5_RUMBLE_RAM,
    TYPE_MBC5_RUMBLE_RAM_BATT
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  chdu_hdr_if  hdr_ch ();
  chdu_info_if info_ch ();
  chdu_cfg_if  cfg_ch ();

  cartridge_header_decoder_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .hdr  (hdr_ch),
    .info (info_ch),
    .cfg  (cfg_ch)
  );

  always #1 clk = ~clk;

  hdr_t        header_queue [$];   // header requests not yet accepted
  logic [23:0] limit_writes [$];   // ROM limit writes not yet accepted
  info_t       expected_info [$];  // decoded info owed by the block, oldest first

  logic [23:0] rom_limit = ROM_LIMIT_RESET;  // bench copy of the limit register
  int unsigned error_count   = 0;
  int unsigned headers_taken = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_gap      = 0;
  int unsigned sink_gap      = 0;
  bit          calm          = 1'b0;  // set for the closing phase: no idling either side
  logic        hold_long     = 1'b0;

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Image size that a ROM code stands for; 0 marks a code with no meaning.
  function automatic logic [31:0] rom_image_size(logic [7:0] code);
    logic [31:0] size;
    size = 32'd0;
    if (code <= ROM_CODE_MAX_POW2)
      size = 32'(32 * KIB) << code;
    else if (code == ROM_CODE_72_BANKS)
      size = 32'(72 * 16 * KIB);
    else if (code == ROM_CODE_80_BANKS)
      size = 32'(80 * 16 * KIB);
    else if (code == ROM_CODE_96_BANKS)
      size = 32'(96 * 16 * KIB);
    return size;
  endfunction

  // What the block should report for one header under a given ROM limit.
  // Any rejection, at decode or at the layout rules, yields an all-zero record.
  function automatic info_t decode_header(hdr_t h, logic [23:0] limit);
    info_t       r;
    logic [31:0] rom;
    logic [17:0] ram;
    logic        ok;
    r   = '0;
    ok  = 1'b0;
    rom = rom_image_size(h.rom_id);
    if (h.header_length < HEADER_MIN_LEN || h.ram_id > RAM_CODE_MAX || rom == 32'd0 ||
        h.image_bytes != rom || rom > {8'h00, limit})
      return '0;
    case (h.ram_id[2:0])
      3'd1:    ram = RAM_2K;
      3'd2:    ram = RAM_8K;
      3'd3:    ram = RAM_32K;
      3'd4:    ram = RAM_128K;
      3'd5:    ram = RAM_64K;
      default: ram = RAM_NONE;
    endcase
    r.rom_bytes   = rom[23:0];
    r.ram_bytes   = ram;
    r.colour_flag = h.cgb_byte[COLOUR_BIT];
    case (h.type_code)
      TYPE_ROM_ONLY: begin
        r.mapper_kind = MAPPER_NONE;
        ok = rom == ROM_32K && ram == RAM_NONE;
      end
      TYPE_ROM_RAM, TYPE_ROM_RAM_BATT: begin
        r.mapper_kind = MAPPER_NONE;
        ok = rom == ROM_32K && ram != RAM_NONE && ram <= RAM_8K;
      end
      TYPE_MBC1, TYPE_MBC1_RAM, TYPE_MBC1_RAM_BATT: begin
        // plain MBC1 must have no RAM, the RAM variants must have some
        r.mapper_kind = MAPPER_MBC1;
        ok = rom <= ROM_2M && ram <= RAM_32K && !(rom > ROM_512K && ram > RAM_8K) &&
             ((h.type_code == TYPE_MBC1) == (ram == RAM_NONE));
      end
      TYPE_MBC2, TYPE_MBC2_BATT: begin
        // internal cells replace the header RAM size; the code itself must be zero
        r.mapper_kind = MAPPER_MBC2;
        r.ram_bytes   = MBC2_RAM_CELLS;
        ok = rom <= ROM_256K && h.ram_id == 8'h00;
      end
      TYPE_MBC3_RTC_BATT, TYPE_MBC3: begin
        r.mapper_kind    = MAPPER_MBC3;
        r.wide_bank_flag = rom > ROM_2M;
        ok = ram == RAM_NONE && rom <= ROM_4M;
      end
      TYPE_MBC3_RTC_RAM_BATT, TYPE_MBC3_RAM, TYPE_MBC3_RAM_BATT: begin
        r.mapper_kind    = MAPPER_MBC3;
        r.wide_bank_flag = rom > ROM_2M || ram > RAM_32K;
        ok = ram != RAM_NONE && rom <= ROM_4M && ram <= RAM_64K;
      end
      // MBC5 takes every decodable ROM size, so only RAM matters
      TYPE_MBC5: begin
        r.mapper_kind = MAPPER_MBC5;
        ok = ram == RAM_NONE;
      end
      TYPE_MBC5_RUMBLE: begin
        r.mapper_kind = MAPPER_MBC5_RUMBLE;
        ok = ram == RAM_NONE;
      end
      TYPE_MBC5_RAM, TYPE_MBC5_RAM_BATT: begin
        r.mapper_kind = MAPPER_MBC5;
        ok = ram != RAM_NONE;
      end
      TYPE_MBC5_RUMBLE_RAM, TYPE_MBC5_RUMBLE_RAM_BATT: begin
        r.mapper_kind = MAPPER_MBC5_RUMBLE;
        ok = ram != RAM_NONE && ram <= RAM_64K;
      end
      default: ok = 1'b0;
    endcase
    r.clock_flag   = h.type_code == TYPE_MBC3_RTC_BATT || h.type_code == TYPE_MBC3_RTC_RAM_BATT;
    r.battery_flag = h.type_code inside {TYPE_MBC1_RAM_BATT, TYPE_MBC2_BATT, TYPE_ROM_RAM_BATT,
                                         TYPE_MBC3_RTC_BATT, TYPE_MBC3_RTC_RAM_BATT,
                                         TYPE_MBC3_RAM_BATT, TYPE_MBC5_RAM_BATT,
                                         TYPE_MBC5_RUMBLE_RAM_BATT};
    r.supported    = 1'b1;
    return ok ? r : '0;
  endfunction

  function automatic hdr_t make_header(logic [7:0] type_code, logic [7:0] rom_id,
                                       logic [7:0] ram_id, logic [7:0] cgb_byte,
                                       logic [15:0] header_length, logic [31:0] image_bytes);
    hdr_t h;
    h.type_code     = type_code;
    h.rom_id        = rom_id;
    h.ram_id        = ram_id;
    h.cgb_byte      = cgb_byte;
    h.header_length = header_length;
    h.image_bytes   = image_bytes;
    return h;
  endfunction

  // Mostly well-formed headers (known type, known codes, matching image size) with
  // random content; the rest is pure noise or a header broken in one field.
  function automatic hdr_t random_header();
    hdr_t        h;
    int unsigned pick;
    h.type_code = KNOWN_TYPES[$urandom_range(0, 18)];
    pick = $urandom_range(0, 9);
    if (pick < 3)
      h.rom_id = 8'h00;
    else if (pick < 8)
      h.rom_id = 8'($urandom_range(1, ROM_CODE_MAX_POW2));
    else
      h.rom_id = ROM_CODE_72_BANKS + 8'($urandom_range(0, 2));
    h.ram_id        = 8'($urandom_range(0, RAM_CODE_MAX));
    h.cgb_byte      = 8'($urandom);
    h.header_length = 16'($urandom_range(HEADER_MIN_LEN, 16'hFFFF));
    h.image_bytes   = rom_image_size(h.rom_id);
    case ($urandom_range(0, 19))
      0: h = make_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom), $urandom);
      1: h.image_bytes = h.image_bytes ^ (32'd1 << $urandom_range(0, 31));
      2: h.header_length = 16'($urandom_range(0, HEADER_MIN_LEN - 1));
      3: h.ram_id = 8'($urandom_range(RAM_CODE_MAX + 1, 255));
      4: h.type_code = 8'($urandom);
      5: h.rom_id = 8'($urandom);
      default: ;
    endcase
    return h;
  endfunction

  // Edge cases: size extremes, the odd 72/80/96-bank codes, every mapper type,
  // short header, unknown codes, image size mismatch and the layout rules.
  task automatic queue_directed();
    header_queue.push_back(make_header(TYPE_ROM_ONLY, 8'h00, 8'h00, 8'h80, HEADER_MIN_LEN,
                                       32 * KIB));
    header_queue.push_back(make_header(TYPE_ROM_ONLY, 8'h00, 8'h00, 8'h80,
                                       16'(HEADER_MIN_LEN - 1), 32 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5, 8'h01, 8'h00, 8'h00, 16'h0000, 64 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5, 8'h01, 8'(RAM_CODE_MAX + 1), 8'h00,
                                       16'hFFFF, 64 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5, 8'(ROM_CODE_MAX_POW2 + 1), 8'h00, 8'h00,
                                       16'hFFFF, 32'd0));
    header_queue.push_back(make_header(TYPE_MBC5, ROM_CODE_72_BANKS, 8'h00, 8'h7F, 16'hFFFF,
                                       72 * 16 * KIB));
    header_queue.push_back(make_header(TYPE_MBC1, ROM_CODE_80_BANKS, 8'h00, 8'h80,
                                       HEADER_MIN_LEN, 80 * 16 * KIB));
    header_queue.push_back(make_header(TYPE_MBC3, ROM_CODE_96_BANKS, 8'h00, 8'hC0,
                                       HEADER_MIN_LEN, 96 * 16 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5_RAM, 8'h01, 8'h02, 8'h00, HEADER_MIN_LEN,
                                       64 * KIB + 1));
    header_queue.push_back(make_header(TYPE_MBC5, ROM_CODE_MAX_POW2, 8'h00, 8'h00,
                                       HEADER_MIN_LEN, 32'hFFFF_FFFF));
    header_queue.push_back(make_header(TYPE_MBC5_RAM_BATT, ROM_CODE_MAX_POW2, 8'h04, 8'hFF,
                                       16'hFFFF, 8192 * KIB));
    header_queue.push_back(make_header(TYPE_MBC2_BATT, 8'h03, 8'h00, 8'h00, HEADER_MIN_LEN,
                                       256 * KIB));
    header_queue.push_back(make_header(TYPE_MBC2, 8'h03, 8'h01, 8'h00, HEADER_MIN_LEN,
                                       256 * KIB));
    header_queue.push_back(make_header(TYPE_MBC3_RTC_RAM_BATT, 8'h07, 8'h05, 8'h80,
                                       HEADER_MIN_LEN, 4096 * KIB));
    header_queue.push_back(make_header(TYPE_MBC3_RTC_BATT, 8'h07, 8'h00, 8'h00,
                                       HEADER_MIN_LEN, 4096 * KIB));
    header_queue.push_back(make_header(TYPE_MBC3_RAM_BATT, 8'h06, 8'h03, 8'h00,
                                       HEADER_MIN_LEN, 2048 * KIB));
    header_queue.push_back(make_header(TYPE_MBC3_RAM, ROM_CODE_MAX_POW2, 8'h02, 8'h00,
                                       HEADER_MIN_LEN, 8192 * KIB));
    header_queue.push_back(make_header(TYPE_ROM_RAM_BATT, 8'h00, 8'h02, 8'h00,
                                       HEADER_MIN_LEN, 32 * KIB));
    header_queue.push_back(make_header(TYPE_ROM_RAM, 8'h00, 8'h03, 8'h00, HEADER_MIN_LEN,
                                       32 * KIB));
    header_queue.push_back(make_header(TYPE_MBC1_RAM_BATT, 8'h05, 8'h03, 8'h00,
                                       HEADER_MIN_LEN, 1024 * KIB));
    header_queue.push_back(make_header(TYPE_MBC1_RAM, 8'h04, 8'h03, 8'h00, HEADER_MIN_LEN,
                                       512 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5_RUMBLE_RAM_BATT, ROM_CODE_MAX_POW2, 8'h05,
                                       8'h80, HEADER_MIN_LEN, 8192 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5_RUMBLE_RAM, 8'h02, 8'h04, 8'h00,
                                       HEADER_MIN_LEN, 128 * KIB));
    header_queue.push_back(make_header(TYPE_MBC5_RUMBLE, 8'h02, 8'h00, 8'h00, HEADER_MIN_LEN,
                                       128 * KIB));
    header_queue.push_back(make_header(8'h04, 8'h00, 8'h00, 8'h00, HEADER_MIN_LEN, 32 * KIB));
    header_queue.push_back(make_header(8'hFF, 8'h00, 8'h00, 8'h00, HEADER_MIN_LEN, 32 * KIB));
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) header_queue.push_back(random_header());
  endtask

  // Block is idle once no request is pending or in flight and every result is in.
  task automatic settle();
    while (header_queue.size() != 0 || limit_writes.size() != 0 || expected_info.size() != 0 ||
           hdr_ch.valid || cfg_ch.valid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Limit writes only go out with the pipeline empty.
  task automatic set_rom_limit(logic [23:0] value);
    settle();
    limit_writes.push_back(value);
    settle();
  endtask

  // Sender side. A header request that is up but not taken holds steady; otherwise
  // the next one goes up, sometimes after a random gap.
  always @(posedge clk) begin : request_driver
    logic        next_valid;
    hdr_t        next_data;
    logic        next_cfg_valid;
    logic [23:0] next_cfg_data;
    next_valid     = hdr_ch.valid;
    next_data      = hdr_ch.data;
    next_cfg_valid = cfg_ch.valid;
    next_cfg_data  = cfg_ch.data;
    if (rst) begin
      next_valid     = 1'b0;
      next_cfg_valid = 1'b0;
      send_gap       = 0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready)
        void'(header_queue.pop_front());
      if (!(hdr_ch.valid && !hdr_ch.ready)) begin
        if (send_gap != 0) begin
          send_gap--;
          next_valid = 1'b0;
        end else if (!calm && header_queue.size() != 0 && $urandom_range(0, 5) == 0) begin
          send_gap   = $urandom_range(0, 3);
          next_valid = 1'b0;
        end else if (header_queue.size() != 0) begin
          next_valid = 1'b1;
          next_data  = header_queue[0];
        end else begin
          next_valid = 1'b0;
        end
      end
      // config channel: one write at a time, no gaps needed
      if (cfg_ch.valid && cfg_ch.ready)
        void'(limit_writes.pop_front());
      if (!(cfg_ch.valid && !cfg_ch.ready)) begin
        next_cfg_valid = limit_writes.size() != 0;
        if (limit_writes.size() != 0)
          next_cfg_data = limit_writes[0];
      end
    end
    hdr_ch.valid <= next_valid;
    hdr_ch.data  <= next_data;
    cfg_ch.valid <= next_cfg_valid;
    cfg_ch.data  <= next_cfg_data;
  end

  // Receiver side: random stalls, plus the long hold below.
  always @(posedge clk) begin : result_sink
    logic next_ready;
    if (rst) begin
      next_ready = 1'b0;
      sink_gap   = 0;
    end else if (hold_long) begin
      next_ready = 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      next_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      sink_gap   = $urandom_range(0, 3);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    info_ch.ready <= next_ready;
  end

  // One long receiver hold mid-run while headers keep coming, so both pipeline
  // stages fill and the block has to drop hdr ready.
  initial begin : long_hold
    wait (headers_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  // Predict at header accept, check at result accept, track limit writes.
  always @(posedge clk) begin : monitor
    info_t want;
    info_t got;
    string diffs;
    if (!rst) begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        expected_info.push_back(decode_header(hdr_ch.data, rom_limit));
        headers_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready)
        rom_limit = cfg_ch.data;
      if (info_ch.valid && info_ch.ready) begin
        got = info_ch.data;
        if (expected_info.size() == 0) begin
          report_error($sformatf("result with nothing outstanding: %h", got));
        end else begin
          want  = expected_info.pop_front();
          diffs = "";
          if (got.supported != want.supported)
            diffs = {diffs, $sformatf(" supported %0d/%0d", got.supported, want.supported)};
          if (got.mapper_kind != want.mapper_kind)
            diffs = {diffs, $sformatf(" mapper_kind %0d/%0d", got.mapper_kind,
                                      want.mapper_kind)};
          if (got.rom_bytes != want.rom_bytes)
            diffs = {diffs, $sformatf(" rom_bytes %0d/%0d", got.rom_bytes, want.rom_bytes)};
          if (got.ram_bytes != want.ram_bytes)
            diffs = {diffs, $sformatf(" ram_bytes %0d/%0d", got.ram_bytes, want.ram_bytes)};
          if (got.colour_flag != want.colour_flag)
            diffs = {diffs, $sformatf(" colour_flag %0d/%0d", got.colour_flag,
                                      want.colour_flag)};
          if (got.battery_flag != want.battery_flag)
            diffs = {diffs, $sformatf(" battery_flag %0d/%0d", got.battery_flag,
                                      want.battery_flag)};
          if (got.clock_flag != want.clock_flag)
            diffs = {diffs, $sformatf(" clock_flag %0d/%0d", got.clock_flag,
                                      want.clock_flag)};
          if (got.wide_bank_flag != want.wide_bank_flag)
            diffs = {diffs, $sformatf(" wide_bank_flag %0d/%0d", got.wide_bank_flag,
                                      want.wide_bank_flag)};
          if (diffs != "")
            report_error($sformatf("result %0d (got/expected):%s", results_seen, diffs));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Phases, each under its own ROM limit: reset value, zero (rejects all),
  // just under 8 MiB, exactly the 96-bank size, a random value, and a closing
  // phase at 8 MiB with no idling on either side.
  initial begin : sequencer
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    set_rom_limit(ROM_LIMIT_RESET);
    queue_directed();
    queue_random(150);
    set_rom_limit(24'h000000);
    queue_random(30);
    set_rom_limit(24'h7FFFFF);
    queue_random(60);
    set_rom_limit(ROM_96_BANKS);
    queue_random(60);
    set_rom_limit(24'($urandom_range(ROM_32K, ROM_8M)));
    queue_random(40);
    set_rom_limit(ROM_8M);
    calm = 1'b1;
    queue_random(60);
    settle();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
